[design/maf_pkg.sv]
// moving average filter: shared types and constants
// used by the interfaces, front, back and top level
package maf_pkg;

  localparam int SampleW = 16;
  localparam int CountW = 7;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 7;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    REG_WINDOW = 1'b0,
    REG_RECENT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                       clear;
    logic signed [SampleW-1:0]  sample;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_AVG,
    ST_DIV_REC,
    ST_OUT
  } back_state_t;

endpackage

[design/maf_if.sv]
// moving average filter: handshake channel interfaces
// depends on maf_pkg
interface maf_in_if import maf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [0:0]         op;
  logic signed [15:0] sample;
  modport source (output valid, op, sample, input ready);
  modport sink (input valid, op, sample, output ready);
endinterface

interface maf_out_if import maf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [15:0] average;
  logic signed [15:0] recent_average;
  logic [6:0]         held_count;
  modport source (output valid, average, recent_average, held_count, input ready);
  modport sink (input valid, average, recent_average, held_count, output ready);
endinterface

interface maf_cfg_if import maf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [0:0]         index;
  logic [6:0]         data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/maf_front.sv]
// moving average filter: front end, classifies words into a two-entry queue
// depends on maf_pkg
module maf_front import maf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  maf_in_if.sink in_ch,
  output cmd_t  cmd,
  output logic  cmd_valid,
  input  logic  cmd_ready
);
  cmd_t       q [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       push;
  logic       pop;

  assign in_ch.ready = (count != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign cmd_valid = (count != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].clear <= (op_t'(in_ch.op) == OP_CLEAR);
      q[wr_ptr].sample <= in_ch.sample;
    end
    if (rst) begin
      count <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !in_ch.ready) else $error("queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue count");
  a_empty_no_valid: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> !cmd_valid) else $error("empty queue valid");
endmodule

[design/maf_back.sv]
// moving average filter: back end, ring memory, serial sum and serial divides
// depends on maf_pkg
module maf_back import maf_pkg::*; #(
  parameter int MaxWindow = 64
) (
  input  logic  clk,
  input  logic  rst,
  input  cmd_t  cmd,
  input  logic  cmd_valid,
  output logic  cmd_ready,
  maf_cfg_if.sink cfg_ch,
  maf_out_if.source out_ch
);
  localparam int AW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int CW = $clog2(MaxWindow + 1) > CountW ? $clog2(MaxWindow + 1) : CountW;
  localparam int SW = SampleW + CW;
  localparam int DSTEPS = SW;
  localparam int DCW = $clog2(DSTEPS + 1);

  logic signed [SampleW-1:0] ring [MaxWindow];
  logic [CW-1:0]             win_reg;
  logic [CountW-1:0]         recent_reg;
  logic [CW-1:0]             fill;
  logic [AW-1:0]             slot;
  logic signed [SW-1:0]      sum;
  back_state_t               state, state_next;

  logic [CW-1:0]             win;
  logic [CW-1:0]             recent_w;
  logic                      rec_ok;
  logic [AW-1:0]             wr_slot;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             rd_idx;
  logic signed [SampleW-1:0] rd_data;
  logic [CW-1:0]             n_left;
  logic signed [SW-1:0]      acc;
  logic [SW-1:0]             quo, rem;
  logic [DCW-1:0]            dstep;
  logic                      dneg;
  logic [CW-1:0]             divisor;
  logic [SW:0]               trial;
  logic signed [SampleW-1:0] avg_r, rec_r;
  logic [CountW-1:0]         held_r;
  logic                      out_valid;
  logic                      rd_pending;

  assign win = (win_reg == '0) ? CW'(1) : (win_reg > CW'(MaxWindow)) ? CW'(MaxWindow) : win_reg;
  assign recent_w = CW'(recent_reg);
  assign rec_ok = (recent_w != '0) && (recent_w <= win) && (recent_w <= fill);
  assign cfg_ch.ready = 1'b1;
  assign cmd_ready = (state == ST_IDLE) && !out_valid;

  // slot the next sample goes to; while idle the memory keeps its old word read out
  assign wr_slot = (CW'(slot) >= win) ? '0 : slot;
  assign rd_addr = (state == ST_IDLE) ? wr_slot : rd_idx;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (cmd_valid && cmd_ready) state_next = cmd.clear ? ST_OUT : ST_DIV_AVG;
      ST_DIV_AVG: if (dstep == DCW'(DSTEPS)) state_next = rec_ok ? ST_SUM : ST_OUT;
      ST_SUM:     if (n_left == '0 && !rd_pending) state_next = ST_DIV_REC;
      ST_DIV_REC: if (dstep == DCW'(DSTEPS)) state_next = ST_OUT;
      ST_OUT:     state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  assign trial = {rem[SW-2:0], quo[SW-1]} - {{(SW+1-CW){1'b0}}, divisor};

  always_ff @(posedge clk) begin
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      win_reg <= CW'(64);
      recent_reg <= CountW'(1);
      fill <= '0;
      slot <= '0;
      sum <= '0;
      out_valid <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (cfg_ch.valid) begin
        unique case (reg_idx_t'(cfg_ch.index))
          REG_WINDOW: begin
            win_reg <= CW'(cfg_ch.data);
            fill <= '0;
            slot <= '0;
            sum <= '0;
          end
          REG_RECENT: recent_reg <= cfg_ch.data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: if (cmd_valid && cmd_ready) begin
          if (cmd.clear) begin
            fill <= '0;
            slot <= '0;
            sum <= '0;
            avg_r <= '0;
            rec_r <= '0;
            held_r <= '0;
          end else begin
            ring[wr_slot] <= cmd.sample;
            if (fill < win) begin
              sum <= sum + SW'(cmd.sample);
              fill <= fill + 1'b1;
              divisor <= fill + 1'b1;
              quo <= (sum + SW'(cmd.sample)) < 0 ? -(sum + SW'(cmd.sample))
                                                 : sum + SW'(cmd.sample);
              dneg <= (sum + SW'(cmd.sample)) < 0;
            end else begin
              sum <= sum - SW'(rd_data) + SW'(cmd.sample);
              divisor <= fill;
              quo <= (sum - SW'(rd_data) + SW'(cmd.sample)) < 0
                     ? -(sum - SW'(rd_data) + SW'(cmd.sample))
                     : sum - SW'(rd_data) + SW'(cmd.sample);
              dneg <= (sum - SW'(rd_data) + SW'(cmd.sample)) < 0;
            end
            slot <= (CW'(wr_slot) + 1'b1 >= win) ? '0 : wr_slot + 1'b1;
            rd_idx <= wr_slot;
            rem <= '0;
            dstep <= '0;
          end
        end
        ST_DIV_AVG: begin
          if (dstep == DCW'(DSTEPS)) begin
            avg_r <= SampleW'(dneg ? -quo : quo);
            held_r <= CountW'(fill);
            rec_r <= '0;
            acc <= '0;
            n_left <= recent_w;
            rd_pending <= 1'b0;
          end else begin
            if (!trial[SW]) rem <= trial[SW-1:0];
            else rem <= {rem[SW-2:0], quo[SW-1]};
            quo <= {quo[SW-2:0], !trial[SW]};
            dstep <= dstep + 1'b1;
          end
        end
        ST_SUM: begin
          if (rd_pending) acc <= acc + SW'(rd_data);
          if (n_left != '0) begin
            rd_pending <= 1'b1;
            n_left <= n_left - 1'b1;
            rd_idx <= (rd_idx == '0) ? AW'(win - 1'b1) : rd_idx - 1'b1;
          end else if (rd_pending) begin
            rd_pending <= 1'b0;
            quo <= (acc + SW'(rd_data)) < 0 ? -(acc + SW'(rd_data)) : acc + SW'(rd_data);
            dneg <= (acc + SW'(rd_data)) < 0;
            divisor <= recent_w;
            rem <= '0;
            dstep <= '0;
          end
        end
        ST_DIV_REC: begin
          if (dstep == DCW'(DSTEPS)) begin
            rec_r <= SampleW'(dneg ? -quo : quo);
          end else begin
            if (!trial[SW]) rem <= trial[SW-1:0];
            else rem <= {rem[SW-2:0], quo[SW-1]};
            quo <= {quo[SW-2:0], !trial[SW]};
            dstep <= dstep + 1'b1;
          end
        end
        ST_OUT: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.average = avg_r;
  assign out_ch.recent_average = rec_r;
  assign out_ch.held_count = held_r;

  a_fill_le_win: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(MaxWindow)) else $error("fill above max");
  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !cmd_ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid) else $error("result dropped");
endmodule

[design/moving_average_filter_unit.sv]
// Moving average filter over the newest window_length signed 16-bit samples.
// A sample word runs a 23-step restoring divide for the average and, when the
// recent average is valid, a one-entry-per-cycle walk of the ring memory for
// the recent sum and a second 23-step restoring divide; a clear word runs
// neither. The back end takes a new word only when idle and its result is taken.
// A two-word queue decouples input from the worker. Depends on maf_pkg, maf_if.
module moving_average_filter_unit import maf_pkg::*; #(
  parameter int MaxWindow = 64
) (
  input logic clk,
  input logic rst,
  maf_in_if.sink in_ch,
  maf_cfg_if.sink cfg_ch,
  maf_out_if.source out_ch
);
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  maf_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready)
  );

  maf_back #(.MaxWindow(MaxWindow)) u_back (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready), .cfg_ch(cfg_ch), .out_ch(out_ch)
  );
endmodule

[tb/sv/maf_tb_if.sv]
`timescale 1ns / 100ps
// testbench-side view of the filter output channel: a result struct
// with the maf_out_if payload fields; depends on maf_pkg
package maf_tb_pkg;
  import maf_pkg::*;

  typedef struct packed {
    logic signed [15:0] average;
    logic signed [15:0] recent_average;
    logic [6:0]         held_count;
  } filter_result_t;
endpackage

[tb/sv/moving_average_filter_unit_tb.sv]
`timescale 1ns / 100ps
// testbench for moving_average_filter_unit: random and directed sample/clear words
// with a software ring predictor; depends on maf_pkg, maf_if, maf_tb_if
module moving_average_filter_unit_tb;
  import maf_pkg::*;
  import maf_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  maf_in_if  in_ch ();
  maf_cfg_if cfg_ch ();
  maf_out_if out_ch ();

  moving_average_filter_unit u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cfg_ch(cfg_ch), .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] sample;
  } filter_word_t;

  filter_word_t   pending_words[$];
  filter_result_t expected_results[$];

  // predictor state
  logic signed [15:0] ring[64];
  longint             sum_acc;
  int                 fill;
  int                 slot_w;
  int                 win_reg;
  int                 recent_reg;

  int  mismatches = 0;
  bit  quiet_in = 0;
  bit  quiet_out = 0;
  bit  in_taken = 0;
  int  busy_cycles = 0;

  function automatic int eff_win();
    if (win_reg < 1) return 1;
    if (win_reg > 64) return 64;
    return win_reg;
  endfunction

  function automatic filter_result_t predict_filter(filter_word_t w);
    filter_result_t r;
    int win, s, idx;
    longint acc;
    win = eff_win();
    r = '0;
    if (w.op == OP_CLEAR) begin
      sum_acc = 0; fill = 0; slot_w = 0;
      return r;
    end
    if (slot_w >= win) slot_w = 0;
    s = w.sample;
    if (fill < win) begin
      sum_acc += s;
      fill++;
    end else begin
      sum_acc = sum_acc - ring[slot_w] + s;
    end
    ring[slot_w] = w.sample;
    slot_w++;
    if (slot_w >= win) slot_w = 0;
    r.average = 16'(sum_acc / fill);
    if (recent_reg >= 1 && recent_reg <= win && recent_reg <= fill) begin
      acc = 0;
      idx = (slot_w + win - 1) % win;
      for (int n = 0; n < recent_reg; n++) begin
        acc += ring[idx];
        idx = (idx + win - 1) % win;
      end
      r.recent_average = 16'(acc / recent_reg);
    end
    r.held_count = 7'(fill);
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_words.size() > 0 && (quiet_in || $urandom_range(99) >= 6)) begin
        in_ch.valid  <= 1'b1;
        in_ch.op     <= pending_words[0].op;
        in_ch.sample <= pending_words[0].sample;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // prediction at acceptance
  always @(posedge clk) begin
    in_taken <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      expected_results.push_back(predict_filter(filter_word_t'({in_ch.op, in_ch.sample})));
      void'(pending_words.pop_front());
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rst ? 1'b0 : (quiet_out || $urandom_range(99) >= 6);
  end

  // monitor
  always @(posedge clk) begin
    filter_result_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.average, out_ch.recent_average, out_ch.held_count};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, int value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= 7'(value);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_WINDOW) begin
      win_reg = value; sum_acc = 0; fill = 0; slot_w = 0;
    end else begin
      recent_reg = value;
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain_words();
    while (pending_words.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic push_sample(logic signed [15:0] s);
    pending_words.push_back('{OP_SAMPLE, s});
  endtask

  task automatic push_clear();
    pending_words.push_back('{OP_CLEAR, 16'($urandom)});
  endtask

  initial begin
    int wsel[6];
    int rsel[6];
    wsel = '{1, 64, 3, 17, 2, 40};
    rsel = '{1, 64, 0, 5, 3, 41};
    in_ch.valid = 1'b0; in_ch.op = '0; in_ch.sample = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_WINDOW; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    win_reg = 64; recent_reg = 1; sum_acc = 0; fill = 0; slot_w = 0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: extremes, clear, window and recent edge cases
    write_reg(REG_WINDOW, 3);
    write_reg(REG_RECENT, 2);
    push_sample(16'sh7fff); push_sample(16'sh7fff); push_sample(16'sh7fff);
    push_sample(16'sh8000); push_sample(16'sh8000); push_sample(-16'sd1);
    push_sample(16'sd1); push_sample(16'sh8000); push_clear();
    push_sample(16'sd5); push_sample(-16'sd7); push_clear(); push_clear();
    drain_words();
    write_reg(REG_RECENT, 4);
    push_sample(-16'sd3); push_sample(16'sd2); push_sample(16'sd9); push_sample(16'sd4);
    drain_words();
    write_reg(REG_WINDOW, 0);
    write_reg(REG_RECENT, 0);
    push_sample(16'sh7fff); push_sample(-16'sd9); push_sample(16'sh5555);
    push_sample(16'shaaaa);
    drain_words();
    write_reg(REG_WINDOW, 127);
    write_reg(REG_RECENT, 127);
    for (int i = 0; i < 5; i++) push_sample(16'($urandom));
    drain_words();

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_WINDOW, wsel[ph]);
      write_reg(REG_RECENT, rsel[ph]);
      quiet_in = (ph == 2);
      quiet_out = (ph == 2);
      for (int i = 0; i < 115; i++) begin
        if ($urandom_range(99) < 3) push_clear();
        else if ($urandom_range(9) == 0)
          push_sample($urandom_range(1) ? 16'sh7fff : 16'sh8000);
        else push_sample(16'($urandom));
      end
      drain_words();
    end
    quiet_in = 0; quiet_out = 0;

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule

[filelist.f]
design/maf_pkg.sv
design/maf_if.sv
design/maf_front.sv
design/maf_back.sv
design/moving_average_filter_unit.sv
tb/sv/maf_tb_if.sv
tb/sv/moving_average_filter_unit_tb.sv
